// ===== hdl/binomial_blur_3x3_assert.svh =====
// Assertion macros for the binomial_blur_3x3 block.
// Included by the top level; it depends on nothing else.
`ifndef BINOMIAL_BLUR_3X3_ASSERT_SVH
`define BINOMIAL_BLUR_3X3_ASSERT_SVH
`ifndef ASSERT_OFF
`define BB3_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BB3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BB3_ASSERT(lbl, clk, rst_n, prop, msg)
`define BB3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/bb3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 binomial blur.
// Used by every module of the block; depends on nothing.
package bb3_pkg;

    localparam int CHANNEL_BITS  = 16;
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int FIFO_DEPTH    = 8;
    localparam int RGB_BITS      = 3 * CHANNEL_BITS;

    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = 12'd480;

    localparam int COL_TAG_BITS = 11;
    localparam int ROW_BITS     = 12;

    localparam int SUM_BITS   = CHANNEL_BITS + 6;
    localparam int X_BITS     = SUM_BITS - 1;
    localparam int DIV_SHIFT  = CHANNEL_BITS + 7;
    localparam int MULT_BITS  = DIV_SHIFT - 2;
    localparam int PROD_BITS  = X_BITS + MULT_BITS;
    localparam logic [MULT_BITS-1:0] DIV_MULT =
        MULT_BITS'(((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9);
    localparam logic [SUM_BITS:0] ROUND_BIAS = (SUM_BITS + 1)'(18);

    typedef logic [CHANNEL_BITS-1:0] t_chan;
    typedef logic [SUM_BITS-1:0]     t_sum;
    typedef t_sum [2:0]              t_sum3;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    typedef struct packed {
        t_chan red_in;
        t_chan green_in;
        t_chan blue_in;
        logic  frame_start;
    } t_pix_in;

    typedef struct packed {
        t_chan                   red_out;
        t_chan                   green_out;
        t_chan                   blue_out;
        t_chan                   alpha_out;
        logic [COL_TAG_BITS-1:0] center_col;
        logic [ROW_BITS-1:0]     center_row;
        logic                    frame_last;
    } t_pix_out;

    typedef struct packed {
        logic [COL_TAG_BITS-1:0] center_col;
        logic [ROW_BITS-1:0]     center_row;
        logic                    frame_last;
    } t_tag;

endpackage

// ===== hdl/bb3_ram.sv =====
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// Defaults come from bb3_pkg.
module bb3_ram #(
    parameter int WIDTH = bb3_pkg::RGB_BITS,
    parameter int DEPTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bb3_div36.sv =====
`timescale 1ns / 1ps
// Rounded division of three weighted sums by 36 through a reciprocal multiply.
// Two register stages; depends on bb3_pkg.
module bb3_div36 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bb3_pkg::t_sum3    i_sum,
    input  bb3_pkg::t_tag     i_tag,
    output logic              o_valid,
    output bb3_pkg::t_pix_out o_data
);
    import bb3_pkg::*;

    typedef logic [2:0][PROD_BITS-1:0] t_prod3;

    logic [SUM_BITS:0]   biased [3];
    logic [X_BITS-1:0]   quarter [3];
    t_prod3              n_prod;
    t_prod3              r_prod;
    t_tag                r_tag;
    logic                r_a_valid;
    logic                r_b_valid;
    t_pix_out            r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            biased[i]  = {1'b0, i_sum[i]} + ROUND_BIAS;
            quarter[i] = biased[i][SUM_BITS:2];
            n_prod[i]  = PROD_BITS'(quarter[i]) * PROD_BITS'(DIV_MULT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
        r_prod                <= n_prod;
        r_tag                 <= i_tag;
        r_out.red_out         <= r_prod[0][DIV_SHIFT +: CHANNEL_BITS];
        r_out.green_out       <= r_prod[1][DIV_SHIFT +: CHANNEL_BITS];
        r_out.blue_out        <= r_prod[2][DIV_SHIFT +: CHANNEL_BITS];
        r_out.alpha_out       <= '1;
        r_out.center_col      <= r_tag.center_col;
        r_out.center_row      <= r_tag.center_row;
        r_out.frame_last      <= r_tag.frame_last;
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_out;

endmodule

// ===== hdl/bb3_fifo.sv =====
`timescale 1ns / 1ps
// Small output queue of blurred pixels with a show-ahead read side.
// Depends on bb3_pkg.
module bb3_fifo #(
    parameter int DEPTH = bb3_pkg::FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bb3_pkg::t_pix_out i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output bb3_pkg::t_pix_out o_data
);
    import bb3_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_pix_out        r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(pop);
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/binomial_blur_3x3.sv =====
// Streaming 3x3 binomial blur (kernel 1 4 1 / 4 16 4 / 1 4 1, sum divided by 36
// with rounding) of RGB pixels in raster order. The block takes one pixel per
// clock while o_in_ready is high; the line stores are read and written once per
// pixel. A blurred interior pixel goes through the stage-1 and stage-2 registers,
// the divider stages and the output queue once the pixel that completes its
// window is accepted. After reset the line stores are cleared, one entry a cycle,
// while input stays stalled; configuration writes are taken during that time.
// Depends on bb3_pkg, bb3_ram, bb3_div36, bb3_fifo and the assertion header.
`timescale 1ns / 1ps
`include "binomial_blur_3x3_assert.svh"
module binomial_blur_3x3 #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  bb3_pkg::t_pix_in                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output bb3_pkg::t_pix_out                 o_out_data,
    input  logic                              i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [bb3_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import bb3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = CW + 1;
    localparam int PW = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        t_rgb top;
        t_rgb mid;
        t_rgb bot;
    } t_col;

    function automatic t_sum col_sum(t_col c, int ch);
        t_chan a;
        t_chan b;
        t_chan d;
        a = c.top[(2 - ch) * CHANNEL_BITS +: CHANNEL_BITS];
        b = c.mid[(2 - ch) * CHANNEL_BITS +: CHANNEL_BITS];
        d = c.bot[(2 - ch) * CHANNEL_BITS +: CHANNEL_BITS];
        return t_sum'(a) + (t_sum'(b) << 2) + t_sum'(d);
    endfunction

    logic [CFG_BITS-1:0] r_frame_width;
    logic [CFG_BITS-1:0] r_frame_height;
    logic [CW-1:0]       r_col;
    logic [ROW_BITS-1:0] r_row;
    logic                r_clr_active;
    logic [CW-1:0]       r_clr_addr;
    logic [PW-1:0]       r_pending;
    logic [PW-1:0]       n_pending;

    logic                r_s1_valid;
    logic                r_s1_emit;
    logic [CW-1:0]       r_s1_addr;
    t_rgb                r_s1_pix;
    t_tag                r_s1_tag;
    logic                r_s1_fwd;
    t_rgb                r_s1_fwd_up;
    t_rgb                r_s1_fwd_mid;
    t_col                r_win0;
    t_col                r_win1;
    logic                r_s2_valid;
    t_sum3               r_s2_sum;
    t_tag                r_s2_tag;

    logic [WB-1:0]       w_eff;
    logic [ROW_BITS-1:0] h_eff;
    logic [CW-1:0]       col_cur;
    logic [ROW_BITS-1:0] row_cur;
    logic [WB-1:0]       col_inc;
    logic [ROW_BITS:0]   row_inc;
    logic                col_wrap;
    logic                row_wrap;
    logic                emit;
    logic                accept;
    logic                pop;
    logic                fwd_hit;
    t_tag                tag_cur;
    t_rgb                pix_cur;
    t_rgb                up_rd;
    t_rgb                mid_rd;
    t_rgb                up_eff;
    t_rgb                mid_eff;
    t_col                col_new;
    t_sum3               n_sum;
    logic                ram_we;
    logic [CW-1:0]       ram_waddr;
    t_rgb                up_wdata;
    t_rgb                mid_wdata;
    logic                div_valid;
    t_pix_out            div_data;

    always_comb begin
        if (r_frame_width < CFG_BITS'(3)) begin
            w_eff = WB'(3);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(r_frame_width);
        end
        h_eff = (r_frame_height < CFG_BITS'(3)) ? ROW_BITS'(3) : r_frame_height;
    end

    assign col_cur  = i_in_data.frame_start ? '0 : r_col;
    assign row_cur  = i_in_data.frame_start ? '0 : r_row;
    assign col_inc  = {1'b0, col_cur} + WB'(1);
    assign row_inc  = {1'b0, row_cur} + (ROW_BITS + 1)'(1);
    assign col_wrap = (col_inc >= w_eff);
    assign row_wrap = (row_inc >= {1'b0, h_eff});
    assign emit     = (col_cur >= CW'(2)) && (row_cur >= ROW_BITS'(2));

    assign tag_cur.center_col = COL_TAG_BITS'(col_cur - CW'(1));
    assign tag_cur.center_row = row_cur - ROW_BITS'(1);
    assign tag_cur.frame_last = ({1'b0, col_cur} == w_eff - WB'(1)) &&
                                (row_cur == h_eff - ROW_BITS'(1));

    assign pix_cur.red   = i_in_data.red_in;
    assign pix_cur.green = i_in_data.green_in;
    assign pix_cur.blue  = i_in_data.blue_in;

    assign o_in_ready = !r_clr_active && (r_pending < PW'(FIFO_DEPTH));
    assign accept     = i_in_valid && o_in_ready;
    assign pop        = o_out_valid && i_out_ready;
    assign n_pending  = r_pending + PW'(accept && emit) - PW'(pop);
    assign fwd_hit    = r_s1_valid && (r_s1_addr == col_cur);

    // A pixel that reads the entry the previous pixel is writing back gets
    // that pixel's write data instead of the stale memory word.
    assign up_eff  = r_s1_fwd ? r_s1_fwd_up : up_rd;
    assign mid_eff = r_s1_fwd ? r_s1_fwd_mid : mid_rd;

    assign col_new.top = up_eff;
    assign col_new.mid = mid_eff;
    assign col_new.bot = r_s1_pix;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = col_sum(r_win0, i) + (col_sum(r_win1, i) << 2) +
                       col_sum(col_new, i);
        end
    end

    assign ram_we    = r_clr_active || r_s1_valid;
    assign ram_waddr = r_clr_active ? r_clr_addr : r_s1_addr;
    assign up_wdata  = r_clr_active ? '0 : mid_eff;
    assign mid_wdata = r_clr_active ? '0 : r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_clr_active   <= 1'b1;
            r_clr_addr     <= '0;
            r_pending      <= '0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data;
                    end
                    REG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_clr_active) begin
                if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                    r_clr_active <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + CW'(1);
                end
            end
            if (accept) begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= row_wrap ? '0 : ROW_BITS'(row_inc);
                end else begin
                    r_col <= CW'(col_inc);
                    r_row <= row_cur;
                end
            end
            r_pending  <= n_pending;
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
        r_s1_emit    <= emit;
        r_s1_addr    <= col_cur;
        r_s1_pix     <= pix_cur;
        r_s1_tag     <= tag_cur;
        r_s1_fwd     <= fwd_hit;
        r_s1_fwd_up  <= mid_eff;
        r_s1_fwd_mid <= r_s1_pix;
        if (r_s1_valid) begin
            r_win0 <= r_win1;
            r_win1 <= col_new;
        end
        r_s2_sum <= n_sum;
        r_s2_tag <= r_s1_tag;
    end

    bb3_ram #(
        .WIDTH (RGB_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (up_wdata),
        .i_raddr (col_cur),
        .o_rdata (up_rd)
    );

    bb3_ram #(
        .WIDTH (RGB_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (mid_wdata),
        .i_raddr (col_cur),
        .o_rdata (mid_rd)
    );

    bb3_div36 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_sum   (r_s2_sum),
        .i_tag   (r_s2_tag),
        .o_valid (div_valid),
        .o_data  (div_data)
    );

    bb3_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (div_valid),
        .i_data  (div_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    `BB3_ASSERT(a_pending_bound, i_clk, i_rst_n, r_pending <= PW'(FIFO_DEPTH), "pending overflow")
    `BB3_ASSERT(a_out_pending, i_clk, i_rst_n, !o_out_valid || r_pending != '0, "uncounted output")
    `BB3_ASSERT_NEXT(a_fwd_taken, i_clk, i_rst_n, accept && fwd_hit, r_s1_fwd, "forward missed")

endmodule
